FILE: rtl/core/multi_pin_debounce_trigger_assert.svh
// Assertion macros used by the checker of the debounce trigger block.
`ifndef MULTI_PIN_DEBOUNCE_TRIGGER_ASSERT_SVH
`define MULTI_PIN_DEBOUNCE_TRIGGER_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define MPDT_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle check failed");

// Condition c must hold in the cycle after a.
`define MPDT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/mpdt_pkg.sv
// ----------------------------------------------------------------------------
// mpdt_pkg
// Constants, codes and types shared by the debounce trigger modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpdt_pkg;

    localparam int MAPPING_SLOTS = 4;
    localparam int PIN_COUNT     = 29;

    localparam int SLOT_W    = 2;
    localparam int PIN_W     = 5;
    localparam int LV_W      = 2 ** PIN_W;
    localparam int MAP_W     = 36;
    localparam int CFG_IDX_W = 3;
    localparam int TIME_W    = 32;
    localparam int DEB_W     = 16;
    localparam int ACT_W     = 4;
    localparam int TSLOT_W   = 8;
    localparam int TRIG_W    = 2;

    localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(MAPPING_SLOTS - 1);
    localparam logic [DEB_W-1:0]  MIN_DEBOUNCE = DEB_W'(5);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LAST = CFG_IDX_W'(MAPPING_SLOTS);

    // Trigger modes.
    localparam logic [TRIG_W-1:0] TRIG_FALL = 2'd0;
    localparam logic [TRIG_W-1:0] TRIG_RISE = 2'd1;
    localparam logic [TRIG_W-1:0] TRIG_BOTH = 2'd2;

    typedef struct packed {
        logic              start;
        logic              step;
        logic              push;
        logic              push_last;
        logic [SLOT_W-1:0] slot;
    } t_dp_cmd;

    typedef struct packed {
        logic enable;
        logic fire;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [ACT_W-1:0]   action_code;
        logic [TSLOT_W-1:0] target_slot;
        logic [PIN_W-1:0]   source_pin;
        logic [SLOT_W-1:0]  mapping_index;
        logic [TIME_W-1:0]  events_total;
    } t_event;

endpackage

`default_nettype wire

FILE: rtl/core/mpdt_ifs.sv
// ----------------------------------------------------------------------------
// mpdt_ifs
// Handshake channels of the debounce trigger: tick input, event output and
// configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpdt_tick_if;
    import mpdt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIME_W-1:0]    now_ms;
    logic [PIN_COUNT-1:0] pin_levels;

    modport source (output valid, output now_ms, output pin_levels, input ready);
    modport sink   (input valid, input now_ms, input pin_levels, output ready);
endinterface

interface mpdt_evt_if;
    import mpdt_pkg::*;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action_code;
    logic [TSLOT_W-1:0] target_slot;
    logic [PIN_W-1:0]   source_pin;
    logic [SLOT_W-1:0]  mapping_index;
    logic [TIME_W-1:0]  events_total;
    logic               last_of_tick;

    modport source (output valid, output action_code, output target_slot,
                    output source_pin, output mapping_index, output events_total,
                    output last_of_tick, input ready);
    modport sink   (input valid, input action_code, input target_slot,
                    input source_pin, input mapping_index, input events_total,
                    input last_of_tick, output ready);
endinterface

interface mpdt_cfg_if;
    import mpdt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MAP_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpdt_ctrl.sv
// ----------------------------------------------------------------------------
// mpdt_ctrl
// Tick sequencer: accepts a tick, walks the mapping slots one per cycle when not
// stalled, and flushes any held event with its end-of-tick mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpdt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick_valid,
    output logic                   o_tick_ready,
    input  wire mpdt_pkg::t_dp_stat i_stat,
    output mpdt_pkg::t_dp_cmd      o_cmd
);
    import mpdt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              stall;

    assign o_tick_ready = (r_state == S_IDLE);
    // A new event can only be taken while the held one has somewhere to go.
    assign stall = i_stat.fire && i_stat.pend_valid && !i_stat.out_free;

    always_comb begin
        n_state         = r_state;
        n_slot          = r_slot;
        o_cmd.start     = 1'b0;
        o_cmd.step      = 1'b0;
        o_cmd.push      = 1'b0;
        o_cmd.push_last = 1'b0;
        o_cmd.slot      = r_slot;
        case (r_state)
            S_IDLE: begin
                if (i_tick_valid && i_stat.enable) begin
                    o_cmd.start = 1'b1;
                    n_slot      = '0;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!stall) begin
                    o_cmd.step = 1'b1;
                    o_cmd.push = i_stat.fire && i_stat.pend_valid;
                    if (r_slot == SLOT_LAST) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mpdt_dp.sv
// ----------------------------------------------------------------------------
// mpdt_dp
// Datapath: configuration registers, per-slot debounce state, event counter,
// held event and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpdt_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire mpdt_pkg::t_dp_cmd                     i_cmd,
    output mpdt_pkg::t_dp_stat                         o_stat,
    input  wire logic [mpdt_pkg::TIME_W-1:0]           i_now_ms,
    input  wire logic [mpdt_pkg::PIN_COUNT-1:0]        i_pin_levels,
    input  wire logic                                  i_cfg_valid,
    input  wire logic [mpdt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mpdt_pkg::MAP_W-1:0]            i_cfg_data,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output mpdt_pkg::t_event                           o_out_event,
    output logic                                       o_out_last
);
    import mpdt_pkg::*;

    logic                     r_enable;
    logic [MAP_W-1:0]         r_map [MAPPING_SLOTS];
    logic [MAPPING_SLOTS-1:0] r_raw, r_stable, r_primed;
    logic [TIME_W-1:0]        r_rct [MAPPING_SLOTS];
    logic [TIME_W-1:0]        r_lft [MAPPING_SLOTS];
    logic [TIME_W-1:0]        r_count;
    logic [TIME_W-1:0]        r_now;
    logic [PIN_COUNT-1:0]     r_levels;
    logic                     r_pend_valid;
    t_event                   r_pend;
    logic                     r_out_valid;
    t_event                   r_out;
    logic                     r_out_last;

    logic [MAP_W-1:0]   m;
    logic [PIN_W-1:0]   pin;
    logic [TRIG_W-1:0]  trig;
    logic [DEB_W-1:0]   deb_raw, deb;
    logic [TIME_W-1:0]  deb_ext, age_raw, age_fire;
    logic [LV_W-1:0]    lv_ext;
    logic               lvl, cur_stable, changed, accept, edge_ok, fire;
    logic               out_free, cfg_map_hit;
    logic [SLOT_W-1:0]  cfg_slot, sl;

    assign sl       = i_cmd.slot;
    assign m        = r_map[sl];
    assign pin      = m[5:1];
    assign trig     = m[7:6];
    assign deb_raw  = m[35:20];
    assign deb      = (deb_raw < MIN_DEBOUNCE) ? MIN_DEBOUNCE : deb_raw;
    assign deb_ext  = TIME_W'(deb);
    // Pins past the last physical one read as zero through the extension.
    assign lv_ext   = LV_W'(r_levels);
    assign lvl      = lv_ext[pin];
    assign cur_stable = r_stable[sl];
    assign changed  = (lvl != r_raw[sl]);
    assign age_raw  = r_now - r_rct[sl];
    assign age_fire = r_now - r_lft[sl];

    // A raw change restarts the debounce window, so it can never be accepted
    // in the same tick.
    assign accept  = r_primed[sl] && !changed && (lvl != cur_stable) && (age_raw >= deb_ext);
    assign edge_ok = (trig == TRIG_BOTH) ||
                     ((trig == TRIG_FALL) && cur_stable && !lvl) ||
                     ((trig == TRIG_RISE) && !cur_stable && lvl);
    assign fire    = m[0] && accept && edge_ok && (age_fire >= deb_ext);

    assign out_free    = !r_out_valid || i_out_ready;
    assign cfg_map_hit = (i_cfg_index >= CFG_MAP_BASE) && (i_cfg_index <= CFG_MAP_LAST);
    assign cfg_slot    = SLOT_W'(i_cfg_index - CFG_MAP_BASE);

    assign o_stat.enable     = r_enable;
    assign o_stat.fire       = fire;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_event = r_out;
    assign o_out_last  = r_out_last;

    // Tick latch and payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now    <= i_now_ms;
            r_levels <= i_pin_levels;
        end
        if (i_cmd.step && fire) begin
            r_pend.action_code   <= m[11:8];
            r_pend.target_slot   <= m[19:12];
            r_pend.source_pin    <= pin;
            r_pend.mapping_index <= sl;
            r_pend.events_total  <= r_count + TIME_W'(1);
        end
        if (i_cmd.push) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_raw        <= '0;
            r_stable     <= '0;
            r_primed     <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < MAPPING_SLOTS; k++) begin
                r_map[k] <= '0;
                r_rct[k] <= '0;
                r_lft[k] <= '0;
            end
        end else begin
            if (i_cmd.step && m[0]) begin
                if (!r_primed[sl]) begin
                    r_raw[sl]    <= lvl;
                    r_stable[sl] <= lvl;
                    r_primed[sl] <= 1'b1;
                end else if (changed) begin
                    r_raw[sl] <= lvl;
                    r_rct[sl] <= r_now;
                end else if (accept) begin
                    r_stable[sl] <= lvl;
                    if (fire) begin
                        r_lft[sl] <= r_now;
                        r_count   <= r_count + TIME_W'(1);
                    end
                end
            end

            if (i_cmd.step && fire) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_valid <= 1'b0;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else if (cfg_map_hit) begin
                    r_map[cfg_slot]    <= i_cfg_data;
                    r_primed[cfg_slot] <= 1'b0;
                    r_rct[cfg_slot]    <= '0;
                    r_lft[cfg_slot]    <= '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/multi_pin_debounce_trigger.sv
// A tick is taken first, then the sequencer evaluates one mapping slot per
// cycle unless stalled by a held event that cannot leave, and then releases
// the last event of the tick, if one is held. Events leave through an output
// register, and a tick may be taken while the last event of the previous one
// still waits there. Ticks that arrive while the block is disabled are taken
// and dropped. The configuration port is always ready.
// ----------------------------------------------------------------------------
// multi_pin_debounce_trigger
// Debounces up to four mapped pins per millisecond tick and emits trigger
// events carrying action, target slot, pin and a running event count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_pin_debounce_trigger (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpdt_tick_if.sink  i_tick,
    mpdt_cfg_if.sink   i_cfg,
    mpdt_evt_if.source o_evt
);
    import mpdt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_event   out_event;
    logic     tick_ready;
    logic     out_valid;
    logic     out_last;

    assign i_tick.ready = tick_ready;
    assign i_cfg.ready  = 1'b1;

    assign o_evt.valid         = out_valid;
    assign o_evt.action_code   = out_event.action_code;
    assign o_evt.target_slot   = out_event.target_slot;
    assign o_evt.source_pin    = out_event.source_pin;
    assign o_evt.mapping_index = out_event.mapping_index;
    assign o_evt.events_total  = out_event.events_total;
    assign o_evt.last_of_tick  = out_last;

    mpdt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (i_tick.valid),
        .o_tick_ready (tick_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    mpdt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_now_ms     (i_tick.now_ms),
        .i_pin_levels (i_tick.pin_levels),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_evt.ready),
        .o_out_valid  (out_valid),
        .o_out_event  (out_event),
        .o_out_last   (out_last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mpdt_checker.sv
// ----------------------------------------------------------------------------
// mpdt_checker
// Port-level checks of the debounce trigger event stream, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_pin_debounce_trigger_assert.svh"

module mpdt_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [mpdt_pkg::SLOT_W-1:0]       i_mapping_index,
    input wire logic [mpdt_pkg::TIME_W-1:0]       i_events_total,
    input wire logic                              i_last_of_tick
);
    import mpdt_pkg::*;

    logic              out_acc;
    logic              r_seen;
    logic              r_prev_last;
    logic [SLOT_W-1:0] r_prev_index;
    logic [TIME_W-1:0] r_prev_total;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_prev_last  <= 1'b1;
            r_prev_index <= '0;
            r_prev_total <= '0;
        end else if (out_acc) begin
            r_seen       <= 1'b1;
            r_prev_last  <= i_last_of_tick;
            r_prev_index <= i_mapping_index;
            r_prev_total <= i_events_total;
        end
    end

    // A stalled word is held unchanged.
    `MPDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_events_total) && $stable(i_mapping_index))

    // Every delivered word carries the count one above its predecessor.
    `MPDT_ASSERT_SAME(a_count_step, i_clk, i_rst_n, out_acc && r_seen, i_events_total == r_prev_total + TIME_W'(1))

    // Within one tick, slots fire in ascending order.
    `MPDT_ASSERT_SAME(a_slot_order, i_clk, i_rst_n, out_acc && !r_prev_last, i_mapping_index > r_prev_index)

endmodule

bind multi_pin_debounce_trigger mpdt_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_evt.valid),
    .i_out_ready     (o_evt.ready),
    .i_mapping_index (o_evt.mapping_index),
    .i_events_total  (o_evt.events_total),
    .i_last_of_tick  (o_evt.last_of_tick)
);

`default_nettype wire
